// ===== sv/fdef_pkg.sv =====
`default_nettype none

package fdef_pkg;

  // Major opcodes (bits 31..26)
  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpCop1    = 6'h11;
  localparam logic [5:0] OpCop1x   = 6'h13;
  localparam logic [5:0] OpLwc1    = 6'h31;
  localparam logic [5:0] OpLdc1    = 6'h35;
  localparam logic [5:0] OpSwc1    = 6'h39;
  localparam logic [5:0] OpSdc1    = 6'h3d;

  // COP1 formats (bits 25..21)
  localparam logic [4:0] FmtS = 5'd16;
  localparam logic [4:0] FmtD = 5'd17;
  localparam logic [4:0] FmtW = 5'd20;

  // Function codes
  localparam logic [5:0] FnSpecialBreak = 6'd1;
  localparam logic [5:0] FnDivS         = 6'd3;
  localparam logic [5:0] FnSqrtS        = 6'd4;
  localparam logic [5:0] FnAbsS         = 6'd5;
  localparam logic [5:0] FnNegS         = 6'd7;
  localparam logic [5:0] FnRoundWS      = 6'd12;
  localparam logic [5:0] FnFloorWS      = 6'd15;
  localparam logic [5:0] FnCvtSS        = 6'd32;
  localparam logic [5:0] FnCvtDS        = 6'd33;
  localparam logic [5:0] FnCvtWS        = 6'd36;
  localparam logic [5:0] FnMaddS        = 6'h20;
  localparam logic [5:0] FnMsubS        = 6'h28;
  localparam logic [5:0] FnNmaddS       = 6'h30;
  localparam logic [5:0] FnNmsubS       = 6'h38;

  // Single-precision fields
  localparam logic [31:0] SignBit  = 32'h8000_0000;
  localparam logic [31:0] MagMask  = 32'h7fff_ffff;
  localparam logic [7:0]  ExpAll   = 8'hff;
  // et + es <= -bias  <=>  raw exp sum <= bias
  localparam logic [8:0]  ExpBias  = 9'd127;

  typedef enum logic [3:0] {
    StRetry    = 4'd0,
    StSkip     = 4'd1,
    StNan      = 4'd2,
    StBds      = 4'd3,
    StFormat   = 4'd4,
    StReserved = 4'd5,
    StCop1x    = 4'd6,
    StLdSt     = 4'd7,
    StNotFpu   = 4'd8,
    StSpecial  = 4'd9
  } status_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic        in_delay_slot;
    logic [31:0] ft_value;
    logic [31:0] fs_value;
    logic [31:0] fr_value;
  } fdef_in_t;

  typedef struct packed {
    status_e     status;
    logic        write_a_enable;
    logic [4:0]  write_a_register;
    logic [31:0] write_a_value;
    logic        write_b_enable;
    logic [4:0]  write_b_register;
    logic [31:0] write_b_value;
    logic        skip_instruction;
  } fdef_out_t;

endpackage

`default_nettype wire

// ===== sv/fpu_denormal_exception_fixup_core.sv =====
// Channel   Ports                     Transfer
// ------    ------------------------  -------------------------------------
// command   start, busy, in_i         edge with start high and busy low
// result    result_valid_o, result_o  the one cycle result_valid_o is high
//
// One instruction per cycle; from command to result it passes an input
// register, then one pass of decode and exponent compare into the result
// register. busy stays low; nothing in the block holds an item back.
// Reset (rst_ni low, asynchronous) empties both stages.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module fpu_denormal_exception_fixup_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire fdef_pkg::fdef_in_t  in_i,
  output logic                  result_valid_o,
  output fdef_pkg::fdef_out_t   result_o
);

  logic                 in_valid_q;
  fdef_pkg::fdef_in_t   in_q;
  logic                 out_valid_q;
  fdef_pkg::fdef_out_t  out_q;
  fdef_pkg::fdef_out_t  out_d;

  // Instruction fields
  logic [5:0] opc;
  logic [4:0] fmt;
  logic [4:0] rt;
  logic [4:0] rs;
  logic [4:0] rd;
  logic [5:0] fn;
  logic [7:0] exp_t;
  logic [7:0] exp_s;
  logic [8:0] exp_sum;
  logic       bds;
  logic       is_unary;
  logic       is_madd;

  assign busy = 1'b0;

  // Control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start && !busy;
      out_valid_q <= in_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= in_i;
    end
    if (in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign opc     = in_q.instruction[31:26];
  assign fmt     = in_q.instruction[25:21];
  assign rt      = in_q.instruction[20:16];
  assign rs      = in_q.instruction[15:11];
  assign rd      = in_q.instruction[10:6];
  assign fn      = in_q.instruction[5:0];
  assign bds     = in_q.in_delay_slot;
  assign exp_t   = in_q.ft_value[30:23];
  assign exp_s   = in_q.fs_value[30:23];
  assign exp_sum = {1'b0, exp_t} + {1'b0, exp_s};

  assign is_unary = (fn == fdef_pkg::FnSqrtS) || (fn == fdef_pkg::FnAbsS) ||
                    (fn == fdef_pkg::FnNegS) ||
                    (fn >= fdef_pkg::FnRoundWS && fn <= fdef_pkg::FnFloorWS) ||
                    (fn == fdef_pkg::FnCvtDS) || (fn == fdef_pkg::FnCvtWS);
  assign is_madd  = (fn == fdef_pkg::FnMaddS) || (fn == fdef_pkg::FnMsubS) ||
                    (fn == fdef_pkg::FnNmaddS) || (fn == fdef_pkg::FnNmsubS);

  // Fixup decode
  always_comb begin
    out_d = '0;
    out_d.status = fdef_pkg::StNotFpu;
    if (opc == fdef_pkg::OpSpecial) begin
      out_d.status = (fn == fdef_pkg::FnSpecialBreak) ? fdef_pkg::StSpecial
                                                      : fdef_pkg::StNotFpu;
    end else if (opc == fdef_pkg::OpCop1) begin
      if (fmt == fdef_pkg::FmtS) begin
        if (fn <= fdef_pkg::FnDivS) begin
          // two-operand ops: flush ft on a, fs on b
          if (exp_t != fdef_pkg::ExpAll && exp_s != fdef_pkg::ExpAll) begin
            if (exp_t == '0) begin
              out_d.write_a_enable   = 1'b1;
              out_d.write_a_register = rt;
              out_d.write_a_value    = in_q.ft_value & fdef_pkg::SignBit;
            end
            if (exp_s == '0) begin
              out_d.write_b_enable   = 1'b1;
              out_d.write_b_register = rs;
              out_d.write_b_value    = in_q.fs_value & fdef_pkg::SignBit;
            end
            out_d.status = fdef_pkg::StRetry;
          end else begin
            out_d.status = fdef_pkg::StNan;
          end
        end else if (is_unary) begin
          if (exp_s == '0) begin
            out_d.write_a_enable   = 1'b1;
            out_d.write_a_register = rs;
            out_d.write_a_value    = in_q.fs_value & fdef_pkg::SignBit;
            out_d.status           = fdef_pkg::StRetry;
          end else begin
            out_d.status = fdef_pkg::StNan;
          end
        end else if (fn == fdef_pkg::FnCvtSS) begin
          if (!bds) begin
            out_d.write_a_enable   = 1'b1;
            out_d.write_a_register = rd;
            out_d.write_a_value    = in_q.fs_value;
            out_d.skip_instruction = 1'b1;
            out_d.status           = fdef_pkg::StSkip;
          end else begin
            out_d.status = fdef_pkg::StBds;
          end
        end else begin
          out_d.status = fdef_pkg::StReserved;
        end
      end else if (fmt == fdef_pkg::FmtD || fmt == fdef_pkg::FmtW) begin
        out_d.status = fdef_pkg::StFormat;
      end else begin
        out_d.status = fdef_pkg::StReserved;
      end
    end else if (opc == fdef_pkg::OpCop1x) begin
      if (is_madd) begin
        if (!bds) begin
          // product underflow: result is just fr, negated for msub/nmadd
          if (exp_sum <= fdef_pkg::ExpBias) begin
            out_d.write_a_enable   = 1'b1;
            out_d.write_a_register = rd;
            out_d.write_a_value    = in_q.fr_value;
            if (fn == fdef_pkg::FnMsubS || fn == fdef_pkg::FnNmaddS) begin
              out_d.write_a_value = in_q.fr_value ^ fdef_pkg::SignBit;
            end
            out_d.skip_instruction = 1'b1;
            out_d.status           = fdef_pkg::StSkip;
          end else begin
            out_d.status = fdef_pkg::StCop1x;
          end
        end else begin
          out_d.write_a_enable = 1'b1;
          if (exp_s <= exp_t && (in_q.fs_value & fdef_pkg::MagMask) != '0) begin
            out_d.write_a_register = rs;
            out_d.write_a_value    = in_q.fs_value & fdef_pkg::SignBit;
          end else begin
            out_d.write_a_register = rt;
            out_d.write_a_value    = in_q.ft_value & fdef_pkg::SignBit;
          end
          out_d.status = fdef_pkg::StRetry;
        end
      end else begin
        out_d.status = fdef_pkg::StCop1x;
      end
    end else if (opc == fdef_pkg::OpLwc1 || opc == fdef_pkg::OpLdc1 ||
                 opc == fdef_pkg::OpSwc1 || opc == fdef_pkg::OpSdc1) begin
      out_d.status = fdef_pkg::StLdSt;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

`default_nettype wire

// ===== sv/fdef_checker.sv =====
`default_nettype none

module fdef_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                result_valid_o,
  input wire fdef_pkg::fdef_out_t result_o
);

  // every accepted command yields a result through the input and result registers
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("accepted command produced no result");

  // no result without a command behind it
  a_result_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without accepted command");

  // an unused write-back a carries zero register and value
  a_unused_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.write_a_enable) |->
      (result_o.write_a_register == '0 && result_o.write_a_value == '0))
    else $error("unused write-back a not zero");

  // skipping always comes with a write to fd, skip status and no write-back b
  a_skip_has_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.skip_instruction) |->
      (result_o.write_a_enable && result_o.status == fdef_pkg::StSkip &&
       !result_o.write_b_enable))
    else $error("skip without fd write");

  // second write-back only in a retry of a two-operand op
  a_write_b_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.write_b_enable) |->
      (result_o.status == fdef_pkg::StRetry && !result_o.skip_instruction))
    else $error("write-back b outside retry");

endmodule

bind fpu_denormal_exception_fixup_core fdef_checker u_fdef_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;

  // Function, format and opcode values the package leaves unnamed
  localparam logic [5:0] FnAddS      = 6'd0;
  localparam logic [5:0] FnSubS      = 6'd1;
  localparam logic [5:0] FnMulS      = 6'd2;
  localparam logic [5:0] FnUndefS    = 6'd6;
  localparam logic [5:0] FnMaddD     = 6'h21;
  localparam logic [5:0] FnShiftSll  = 6'd0;
  localparam logic [4:0] FmtL        = 5'd21;
  localparam logic [4:0] FmtZero     = 5'd0;
  localparam logic [5:0] OpUnused    = 6'h3f;

  localparam int unsigned CycleLimit = 400000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  fdef_pkg::fdef_in_t   in_i;
  logic                 result_valid_o;
  fdef_pkg::fdef_out_t  result_o;

  fdef_pkg::fdef_out_t pending_fixups[$];
  int unsigned         fail_count;
  int unsigned         cycle_count;
  bit                  idle_on;

  fpu_denormal_exception_fixup_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // 4-unit clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Fixup decision for one faulting instruction
  function automatic fdef_pkg::fdef_out_t fixup_predict(fdef_pkg::fdef_in_t cmd);
    fdef_pkg::fdef_out_t r;
    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  fmt;
    logic [4:0]  rt;
    logic [4:0]  rs;
    logic [4:0]  rd;
    logic [7:0]  ex_t;
    logic [7:0]  ex_s;
    logic [8:0]  exp_sum;
    logic [31:0] v;
    opc  = cmd.instruction[31:26];
    fmt  = cmd.instruction[25:21];
    rt   = cmd.instruction[20:16];
    rs   = cmd.instruction[15:11];
    rd   = cmd.instruction[10:6];
    fn   = cmd.instruction[5:0];
    ex_t = cmd.ft_value[30:23];
    ex_s = cmd.fs_value[30:23];
    exp_sum = {1'b0, ex_t} + {1'b0, ex_s};
    r = '0;
    r.status = fdef_pkg::StNotFpu;
    if (opc == fdef_pkg::OpSpecial) begin
      r.status = (fn == fdef_pkg::FnSpecialBreak) ? fdef_pkg::StSpecial
                                                  : fdef_pkg::StNotFpu;
    end else if (opc == fdef_pkg::OpCop1) begin
      if (fmt == fdef_pkg::FmtS) begin
        if (fn <= fdef_pkg::FnDivS) begin
          // two operands: ft flush on port a, fs flush on port b
          if (ex_t != fdef_pkg::ExpAll && ex_s != fdef_pkg::ExpAll) begin
            if (ex_t == 8'h00) begin
              r.write_a_enable   = 1'b1;
              r.write_a_register = rt;
              r.write_a_value    = cmd.ft_value & fdef_pkg::SignBit;
            end
            if (ex_s == 8'h00) begin
              r.write_b_enable   = 1'b1;
              r.write_b_register = rs;
              r.write_b_value    = cmd.fs_value & fdef_pkg::SignBit;
            end
            r.status = fdef_pkg::StRetry;
          end else begin
            r.status = fdef_pkg::StNan;
          end
        end else if (fn == fdef_pkg::FnSqrtS || fn == fdef_pkg::FnAbsS ||
                     fn == fdef_pkg::FnNegS ||
                     (fn >= fdef_pkg::FnRoundWS && fn <= fdef_pkg::FnFloorWS) ||
                     fn == fdef_pkg::FnCvtDS || fn == fdef_pkg::FnCvtWS) begin
          if (ex_s == 8'h00) begin
            r.write_a_enable   = 1'b1;
            r.write_a_register = rs;
            r.write_a_value    = cmd.fs_value & fdef_pkg::SignBit;
            r.status           = fdef_pkg::StRetry;
          end else begin
            r.status = fdef_pkg::StNan;
          end
        end else if (fn == fdef_pkg::FnCvtSS) begin
          if (!cmd.in_delay_slot) begin
            r.write_a_enable   = 1'b1;
            r.write_a_register = rd;
            r.write_a_value    = cmd.fs_value;
            r.skip_instruction = 1'b1;
            r.status           = fdef_pkg::StSkip;
          end else begin
            r.status = fdef_pkg::StBds;
          end
        end else begin
          r.status = fdef_pkg::StReserved;
        end
      end else if (fmt == fdef_pkg::FmtD || fmt == fdef_pkg::FmtW) begin
        r.status = fdef_pkg::StFormat;
      end else begin
        r.status = fdef_pkg::StReserved;
      end
    end else if (opc == fdef_pkg::OpCop1x) begin
      if (fn == fdef_pkg::FnMaddS || fn == fdef_pkg::FnMsubS ||
          fn == fdef_pkg::FnNmaddS || fn == fdef_pkg::FnNmsubS) begin
        if (!cmd.in_delay_slot) begin
          // product exponent underflows when the raw sum is at most the bias
          if (exp_sum <= fdef_pkg::ExpBias) begin
            v = cmd.fr_value;
            if (fn == fdef_pkg::FnMsubS || fn == fdef_pkg::FnNmaddS)
              v = v ^ fdef_pkg::SignBit;
            r.write_a_enable   = 1'b1;
            r.write_a_register = rd;
            r.write_a_value    = v;
            r.skip_instruction = 1'b1;
            r.status           = fdef_pkg::StSkip;
          end else begin
            r.status = fdef_pkg::StCop1x;
          end
        end else begin
          r.write_a_enable = 1'b1;
          if (ex_s <= ex_t && (cmd.fs_value & fdef_pkg::MagMask) != '0) begin
            r.write_a_register = rs;
            r.write_a_value    = cmd.fs_value & fdef_pkg::SignBit;
          end else begin
            r.write_a_register = rt;
            r.write_a_value    = cmd.ft_value & fdef_pkg::SignBit;
          end
          r.status = fdef_pkg::StRetry;
        end
      end else begin
        r.status = fdef_pkg::StCop1x;
      end
    end else if (opc == fdef_pkg::OpLwc1 || opc == fdef_pkg::OpLdc1 ||
                 opc == fdef_pkg::OpSwc1 || opc == fdef_pkg::OpSdc1) begin
      r.status = fdef_pkg::StLdSt;
    end
    return r;
  endfunction

  function automatic logic [31:0] make_insn(logic [5:0] opc, logic [4:0] fmt,
                                            logic [4:0] ft, logic [4:0] fs,
                                            logic [4:0] fd, logic [5:0] fn);
    return {opc, fmt, ft, fs, fd, fn};
  endfunction

  // Mostly short gaps, a few long ones; none while idle_on is clear
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (!idle_on || roll < 12) return 0;
    if (roll < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operand biased toward zero, denormal, inf/nan and the underflow boundary
  function automatic logic [31:0] rand_operand();
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    s = 1'($urandom);
    m = 23'($urandom);
    case ($urandom_range(0, 6))
      0: begin
        e = 8'h00;
        m = '0;
      end
      1: e = 8'h00;
      2: e = fdef_pkg::ExpAll;
      3: e = 8'($urandom_range(1, 127));
      4: e = 8'($urandom_range(60, 68));
      default: e = 8'($urandom);
    endcase
    return {s, e, m};
  endfunction

  // COP1 or COP1X instruction, mostly well-formed .S or multiply-add, with random register fields
  function automatic logic [31:0] rand_fpu_insn();
    logic [31:0] w;
    logic [5:0]  fn;
    logic [5:0]  madd_fns[4];
    madd_fns = '{fdef_pkg::FnMaddS, fdef_pkg::FnMsubS,
                 fdef_pkg::FnNmaddS, fdef_pkg::FnNmsubS};
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: return make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS,
                                w[20:16], w[15:11], w[10:6],
                                6'($urandom_range(FnAddS, fdef_pkg::FnDivS)));
      3, 4: begin
        case ($urandom_range(0, 5))
          0: fn = fdef_pkg::FnSqrtS;
          1: fn = fdef_pkg::FnAbsS;
          2: fn = fdef_pkg::FnNegS;
          3: fn = 6'($urandom_range(fdef_pkg::FnRoundWS, fdef_pkg::FnFloorWS));
          4: fn = fdef_pkg::FnCvtDS;
          default: fn = fdef_pkg::FnCvtWS;
        endcase
        return make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS,
                         w[20:16], w[15:11], w[10:6], fn);
      end
      5: return make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS,
                          w[20:16], w[15:11], w[10:6], fdef_pkg::FnCvtSS);
      6: return make_insn(fdef_pkg::OpCop1, w[25:21], w[20:16], w[15:11],
                          w[10:6], w[5:0]);
      7, 8: return make_insn(fdef_pkg::OpCop1x, w[25:21], w[20:16], w[15:11],
                             w[10:6], madd_fns[$urandom_range(0, 3)]);
      default: return make_insn(fdef_pkg::OpCop1x, w[25:21], w[20:16], w[15:11],
                                w[10:6], w[5:0]);
    endcase
  endfunction

  // Present one command, hold it until the block takes it, then maybe idle
  task automatic send_insn(input logic [31:0] insn, input logic bds,
                           input logic [31:0] ft, input logic [31:0] fs,
                           input logic [31:0] fr);
    fdef_pkg::fdef_in_t cmd;
    bit                 taken;
    int unsigned        gap;
    cmd.instruction   = insn;
    cmd.in_delay_slot = bds;
    cmd.ft_value      = ft;
    cmd.fs_value      = fs;
    cmd.fr_value      = fr;
    start <= 1'b1;
    in_i  <= cmd;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    pending_fixups.push_back(fixup_predict(cmd));
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_fixups.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_special_and_loadstore();
    logic [5:0] ldst_ops[4];
    ldst_ops = '{fdef_pkg::OpLwc1, fdef_pkg::OpLdc1, fdef_pkg::OpSwc1, fdef_pkg::OpSdc1};
    send_insn(make_insn(fdef_pkg::OpSpecial, FmtZero, '0, '0, '0, fdef_pkg::FnSpecialBreak),
              1'b0, '0, '0, '0);
    send_insn(make_insn(fdef_pkg::OpSpecial, '1, '1, '1, '1, FnShiftSll), 1'b1, '1, '1, '1);
    send_insn(32'h0000_0000, 1'b0, '0, '0, '0);
    foreach (ldst_ops[i])
      send_insn({ldst_ops[i], 26'($urandom)}, 1'($urandom), $urandom, $urandom, $urandom);
    send_insn({OpUnused, 26'h3ff_ffff}, 1'b1, '1, '1, '1);
  endtask

  task automatic test_cop1_single();
    // both exponents zero, same register named twice
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd7, 5'd7, 5'd3, FnAddS), 1'b0,
              32'h8000_1234, 32'h0000_0000, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd31, 5'd0, 5'd1, FnSubS), 1'b0,
              32'h007f_ffff, 32'h3f80_0000, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd4, 5'd31, 5'd9, FnMulS), 1'b1,
              32'h3f80_0000, 32'h8000_0000, '0);
    // nan and inf operands stop the flush
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd2, 5'd5, 5'd0,
                        fdef_pkg::FnDivS), 1'b0,
              32'hffc0_0001, 32'h0000_0001, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd2, 5'd5, 5'd0, FnSubS), 1'b0,
              32'h0000_0000, 32'h7f80_0000, '0);
    // unary ops flush fs only
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd0, 5'd17, 5'd6,
                        fdef_pkg::FnSqrtS), 1'b1,
              32'h7fff_ffff, 32'h807f_ffff, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd0, 5'd17, 5'd6,
                        fdef_pkg::FnNegS), 1'b0,
              32'h0000_0000, 32'h3f80_0000, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd1, 5'd30, 5'd6,
                        fdef_pkg::FnCvtWS), 1'b0,
              '0, 32'h7fff_ffff, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd1, 5'd30, 5'd6,
                        fdef_pkg::FnCvtDS), 1'b0,
              '0, 32'h8000_0000, '0);
    // convert to self: copy outside a delay slot, refuse inside one
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd0, 5'd12, 5'd31,
                        fdef_pkg::FnCvtSS), 1'b0,
              '0, 32'hdead_beef, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd0, 5'd12, 5'd31,
                        fdef_pkg::FnCvtSS), 1'b1,
              '0, 32'hdead_beef, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtS, 5'd0, 5'd12, 5'd31, FnUndefS),
              1'b0, '0, '0, '0);
  endtask

  task automatic test_cop1_formats();
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtD, 5'd1, 5'd2, 5'd3, FnAddS),
              1'b0, '0, '0, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, fdef_pkg::FmtW, 5'd1, 5'd2, 5'd3,
                        fdef_pkg::FnCvtSS), 1'b0, '0, '0, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, FmtL, 5'd1, 5'd2, 5'd3, FnAddS), 1'b0, '0, '0, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, FmtZero, 5'd1, 5'd2, 5'd3, FnAddS),
              1'b0, '0, '0, '0);
    send_insn(make_insn(fdef_pkg::OpCop1, '1, '1, '1, '1, '1), 1'b1, '1, '1, '1);
  endtask

  task automatic test_cop1x_multiply_add();
    // raw exponent sum exactly at the bias underflows
    send_insn(make_insn(fdef_pkg::OpCop1x, 5'd9, 5'd1, 5'd2, 5'd20, fdef_pkg::FnMaddS),
              1'b0, 32'h1f80_0000, 32'h2000_0000, 32'h4049_0fdb);
    send_insn(make_insn(fdef_pkg::OpCop1x, 5'd9, 5'd1, 5'd2, 5'd21, fdef_pkg::FnMsubS),
              1'b0, 32'h0000_0000, 32'h3f80_0000, 32'h4049_0fdb);
    send_insn(make_insn(fdef_pkg::OpCop1x, 5'd9, 5'd1, 5'd2, 5'd22, fdef_pkg::FnNmaddS),
              1'b0, 32'h8000_0001, 32'h0000_0000, 32'hc000_0000);
    send_insn(make_insn(fdef_pkg::OpCop1x, 5'd9, 5'd1, 5'd2, 5'd23, fdef_pkg::FnNmsubS),
              1'b0, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff);
    // one past the bias does not
    send_insn(make_insn(fdef_pkg::OpCop1x, 5'd9, 5'd1, 5'd2, 5'd20, fdef_pkg::FnMaddS),
              1'b0, 32'h2000_0000, 32'h2000_0000, 32'h4049_0fdb);
    // delay slot: flush fs when its exponent is not above ft and fs is nonzero
    send_insn(make_insn(fdef_pkg::OpCop1x, 5'd9, 5'd3, 5'd4, 5'd20, fdef_pkg::FnMaddS),
              1'b1, 32'h3f80_0000, 32'h8000_0001, '0);
    send_insn(make_insn(fdef_pkg::OpCop1x, 5'd9, 5'd3, 5'd4, 5'd20, fdef_pkg::FnMsubS),
              1'b1, 32'hbf80_0000, 32'h8000_0000, '0);
    send_insn(make_insn(fdef_pkg::OpCop1x, 5'd9, 5'd3, 5'd4, 5'd20, fdef_pkg::FnNmaddS),
              1'b1, 32'h8000_0000, 32'h3f80_0000, '0);
    send_insn(make_insn(fdef_pkg::OpCop1x, 5'd9, 5'd3, 5'd4, 5'd20, FnMaddD),
              1'b0, '0, '0, '0);
  endtask

  // Mostly well-formed FPU ops with biased operands, some raw noise
  task automatic test_random_mix(input int unsigned count);
    logic [31:0] insn;
    for (int unsigned i = 0; i < count; i++) begin
      // every fourth stretch of 100 runs back to back
      idle_on = ((i / 100) % 4) != 3;
      if (i == count / 2) wait_results_drained();
      insn = ($urandom_range(0, 3) != 0) ? rand_fpu_insn() : $urandom;
      if ($urandom_range(0, 7) == 0)
        send_insn(insn, 1'($urandom), $urandom, $urandom, $urandom);
      else
        send_insn(insn, 1'($urandom), rand_operand(), rand_operand(), rand_operand());
    end
  endtask

  task automatic report_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, label, want, got);
      fail_count++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(negedge clk_i) begin
    fdef_pkg::fdef_out_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_fixups.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, result_o);
        fail_count++;
      end else begin
        want = pending_fixups.pop_front();
        report_field("status", 32'(want.status), 32'(result_o.status));
        report_field("write_a_enable", 32'(want.write_a_enable),
                     32'(result_o.write_a_enable));
        report_field("write_a_register", 32'(want.write_a_register),
                     32'(result_o.write_a_register));
        report_field("write_a_value", want.write_a_value, result_o.write_a_value);
        report_field("write_b_enable", 32'(want.write_b_enable),
                     32'(result_o.write_b_enable));
        report_field("write_b_register", 32'(want.write_b_register),
                     32'(result_o.write_b_register));
        report_field("write_b_value", want.write_b_value, result_o.write_b_value);
        report_field("skip_instruction", 32'(want.skip_instruction),
                     32'(result_o.skip_instruction));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    fail_count  = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_and_loadstore();
    test_cop1_single();
    test_cop1_formats();
    test_cop1x_multiply_add();
    wait_results_drained();
    test_random_mix(1000);

    // let the two-stage pipe empty and check nothing stray follows
    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_fixups.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== fpu_denormal_exception_fixup_core.f =====
sv/fdef_pkg.sv
sv/fpu_denormal_exception_fixup_core.sv
sv/fdef_checker.sv
tb/sv/tb.sv
